@@ src/mgm_pkg.sv @@
package mgm_pkg;

    localparam int unsigned HalfW    = 32;
    localparam int unsigned BlockW   = 64;
    localparam int unsigned KeyRegW  = 64;
    localparam int unsigned NumKeyReg = 4;
    localparam int unsigned NumRounds = 32;
    localparam int unsigned NumRk    = 8;
    localparam int unsigned RotAmt   = 11;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    typedef logic [HalfW-1:0] half_t;
    typedef logic [2:0] rk_idx_t;
    typedef logic [1:0] key_idx_t;
    typedef logic [NumRk-1:0][HalfW-1:0] rk_set_t;

    // Request and result payloads carried by the stream interfaces.
    typedef struct packed {
        logic              cmd;
        logic [BlockW-1:0] block_in;
    } req_t;

    typedef struct packed {
        logic [BlockW-1:0] block_out;
    } rsp_t;

    // One pipeline slot: valid travels with the halves and the direction.
    typedef struct packed {
        logic  valid;
        logic  dec;
        half_t l;
        half_t r;
    } stage_t;

    typedef logic [3:0] nib_t;

    localparam nib_t SBOX [8][16] = '{
        '{4'hc, 4'h4, 4'h6, 4'h2, 4'ha, 4'h5, 4'hb, 4'h9,
          4'he, 4'h8, 4'hd, 4'h7, 4'h0, 4'h3, 4'hf, 4'h1},
        '{4'h6, 4'h8, 4'h2, 4'h3, 4'h9, 4'ha, 4'h5, 4'hc,
          4'h1, 4'he, 4'h4, 4'h7, 4'hb, 4'hd, 4'h0, 4'hf},
        '{4'hb, 4'h3, 4'h5, 4'h8, 4'h2, 4'hf, 4'ha, 4'hd,
          4'he, 4'h1, 4'h7, 4'h4, 4'hc, 4'h9, 4'h6, 4'h0},
        '{4'hc, 4'h8, 4'h2, 4'h1, 4'hd, 4'h4, 4'hf, 4'h6,
          4'h7, 4'h0, 4'ha, 4'h5, 4'h3, 4'he, 4'h9, 4'hb},
        '{4'h7, 4'hf, 4'h5, 4'ha, 4'h8, 4'h1, 4'h6, 4'hd,
          4'h0, 4'h9, 4'h3, 4'he, 4'hb, 4'h4, 4'h2, 4'hc},
        '{4'h5, 4'hd, 4'hf, 4'h6, 4'h9, 4'h2, 4'hc, 4'ha,
          4'hb, 4'h7, 4'h8, 4'h1, 4'h4, 4'h3, 4'he, 4'h0},
        '{4'h8, 4'he, 4'h2, 4'h5, 4'h6, 4'h9, 4'h1, 4'hc,
          4'hf, 4'h4, 4'hb, 4'h0, 4'hd, 4'ha, 4'h3, 4'h7},
        '{4'h1, 4'h7, 4'he, 4'hd, 4'h0, 4'h5, 4'h8, 4'h3,
          4'h4, 4'hf, 4'ha, 4'h6, 4'h9, 4'hc, 4'hb, 4'h2}
    };

    // Round key used by a given round when encrypting.
    function automatic rk_idx_t enc_rk_idx(input int unsigned rnd);
        if (rnd < 24)
            return rk_idx_t'(rnd % 8);
        return rk_idx_t'(7 - (rnd % 8));
    endfunction

    // Round key used by a given round when decrypting.
    function automatic rk_idx_t dec_rk_idx(input int unsigned rnd);
        if (rnd < 8)
            return rk_idx_t'(rnd);
        return rk_idx_t'(7 - (rnd % 8));
    endfunction

endpackage

@@ src/mgm_stream_if.sv @@
interface mgm_stream_if #(
    parameter type payload_t = mgm_pkg::req_t
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ src/mgm_keys.sv @@
module mgm_keys (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  mgm_pkg::key_idx_t              cfg_index,
    input  logic [mgm_pkg::KeyRegW-1:0]    cfg_data,
    output mgm_pkg::rk_set_t               rk
);

    logic [mgm_pkg::NumKeyReg-1:0][mgm_pkg::KeyRegW-1:0] key_reg;

    // Key registers; the user must write them only while the pipeline is empty, the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_we)
        begin
            key_reg[cfg_index] <= cfg_data;
        end
    end

    // Key register 3 holds round keys 0 and 1, register 0 holds 6 and 7.
    always_comb
    begin
        for (int n = 0; n < mgm_pkg::NumRk; n++)
        begin
            if ((n % 2) == 0)
                rk[mgm_pkg::rk_idx_t'(n)] = key_reg[mgm_pkg::key_idx_t'(3 - n / 2)][63:32];
            else
                rk[mgm_pkg::rk_idx_t'(n)] = key_reg[mgm_pkg::key_idx_t'(3 - n / 2)][31:0];
        end
    end

endmodule

@@ src/mgm_round.sv @@
module mgm_round (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  mgm_pkg::stage_t      stage_in,
    input  mgm_pkg::half_t       rk,
    output mgm_pkg::stage_t      stage_out
);

    mgm_pkg::half_t sum;
    mgm_pkg::half_t sub;
    mgm_pkg::half_t rot;
    logic           valid_reg;
    logic           dec_reg;
    mgm_pkg::half_t l_reg;
    mgm_pkg::half_t r_reg;

    // Round function: key add, nibble substitution, rotate left by 11.
    always_comb
    begin
        sum = stage_in.r + rk;
        for (int i = 0; i < 8; i++)
        begin
            sub[4*i +: 4] = mgm_pkg::SBOX[3'(i)][sum[4*i +: 4]];
        end
        rot = {sub[mgm_pkg::HalfW-mgm_pkg::RotAmt-1:0],
               sub[mgm_pkg::HalfW-1:mgm_pkg::HalfW-mgm_pkg::RotAmt]};
    end

    // Valid bit of the slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= stage_in.valid;
        end
    end

    // Feistel step: halves swap, the new right half is f xor left.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dec_reg <= stage_in.dec;
            l_reg   <= stage_in.r;
            r_reg   <= rot ^ stage_in.l;
        end
    end

    assign stage_out = '{valid: valid_reg, dec: dec_reg, l: l_reg, r: r_reg};

endmodule

@@ src/magma_block_cipher.sv @@
// Magma (64-bit block, 256-bit key) cipher engine, fully unrolled.
//
// Requests arrive on cipher_req: cmd selects encryption (0) or decryption
// (1) of block_in. Results leave on cipher_rsp as block_out, in request
// order, one result per request. The 256-bit key is loaded through the
// write port (cfg_we, cfg_index, cfg_data) as four 64-bit words; it must
// only be written while no request is in flight.
//
// Each of the 32 rounds is one pipeline register stage. One request is
// accepted every cycle while the receiver does not stall. The last
// round stage is the output register.
//
// Reset clears every slot's valid bit and the key to all zeros. When the
// receiver stalls with a result waiting, the whole pipeline holds and
// cipher_req.ready drops; ready returns as soon as the result is taken or
// the output slot is empty, so no request is lost or repeated.
module magma_block_cipher (
    input  logic                          clk,
    input  logic                          rst_n,
    mgm_stream_if.sink                    cipher_req,
    mgm_stream_if.source                  cipher_rsp,
    input  logic                          cfg_we,
    input  mgm_pkg::key_idx_t             cfg_index,
    input  logic [mgm_pkg::KeyRegW-1:0]   cfg_data
);

    mgm_pkg::rk_set_t rk;
    mgm_pkg::stage_t  stage [mgm_pkg::NumRounds+1];
    mgm_pkg::req_t    req;
    logic             en;

    mgm_keys u_keys (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rk        (rk)
    );

    // The pipeline advances as a whole unless a result sits unclaimed.
    assign en = !stage[mgm_pkg::NumRounds].valid || cipher_rsp.ready;
    assign cipher_req.ready = en;

    // Feed the first round: low word is the right half.
    assign req = cipher_req.payload;
    assign stage[0] = '{valid: cipher_req.valid,
                        dec:   (req.cmd == mgm_pkg::CMD_DECRYPT),
                        l:     req.block_in[63:32],
                        r:     req.block_in[31:0]};

    // One round per stage, each with its own round key for either direction.
    for (genvar g = 0; g < mgm_pkg::NumRounds; g++)
    begin : g_round
        localparam mgm_pkg::rk_idx_t EncIdx = mgm_pkg::enc_rk_idx(g);
        localparam mgm_pkg::rk_idx_t DecIdx = mgm_pkg::dec_rk_idx(g);
        mgm_pkg::half_t rk_sel;

        assign rk_sel = stage[g].dec ? rk[DecIdx] : rk[EncIdx];

        mgm_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .stage_in  (stage[g]),
            .rk        (rk_sel),
            .stage_out (stage[g+1])
        );
    end

    // The last round does not swap, so undo the stage's swap on output.
    assign cipher_rsp.valid = stage[mgm_pkg::NumRounds].valid;
    assign cipher_rsp.payload = '{block_out: {stage[mgm_pkg::NumRounds].r,
                                              stage[mgm_pkg::NumRounds].l}};

endmodule

@@ test/magma_block_cipher_test.sv @@
`timescale 1ns / 1ps

module magma_block_cipher_test;

    // One accepted request together with the block it must produce.
    typedef struct {
        logic        cmd;
        logic [63:0] block_in;
        logic [63:0] block_out;
    } cipher_job_t;

    // Substitution boxes, nibble 0 uses row 0.
    localparam logic [3:0] SUBST [8][16] = '{
        '{4'hc, 4'h4, 4'h6, 4'h2, 4'ha, 4'h5, 4'hb, 4'h9,
          4'he, 4'h8, 4'hd, 4'h7, 4'h0, 4'h3, 4'hf, 4'h1},
        '{4'h6, 4'h8, 4'h2, 4'h3, 4'h9, 4'ha, 4'h5, 4'hc,
          4'h1, 4'he, 4'h4, 4'h7, 4'hb, 4'hd, 4'h0, 4'hf},
        '{4'hb, 4'h3, 4'h5, 4'h8, 4'h2, 4'hf, 4'ha, 4'hd,
          4'he, 4'h1, 4'h7, 4'h4, 4'hc, 4'h9, 4'h6, 4'h0},
        '{4'hc, 4'h8, 4'h2, 4'h1, 4'hd, 4'h4, 4'hf, 4'h6,
          4'h7, 4'h0, 4'ha, 4'h5, 4'h3, 4'he, 4'h9, 4'hb},
        '{4'h7, 4'hf, 4'h5, 4'ha, 4'h8, 4'h1, 4'h6, 4'hd,
          4'h0, 4'h9, 4'h3, 4'he, 4'hb, 4'h4, 4'h2, 4'hc},
        '{4'h5, 4'hd, 4'hf, 4'h6, 4'h9, 4'h2, 4'hc, 4'ha,
          4'hb, 4'h7, 4'h8, 4'h1, 4'h4, 4'h3, 4'he, 4'h0},
        '{4'h8, 4'he, 4'h2, 4'h5, 4'h6, 4'h9, 4'h1, 4'hc,
          4'hf, 4'h4, 4'hb, 4'h0, 4'hd, 4'ha, 4'h3, 4'h7},
        '{4'h1, 4'h7, 4'he, 4'hd, 4'h0, 4'h5, 4'h8, 4'h3,
          4'h4, 4'hf, 4'ha, 4'h6, 4'h9, 4'hc, 4'hb, 4'h2}
    };

    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned MAX_PRINTED  = 100;

    logic clk = 1'b0;
    logic rst_n;

    logic                          cfg_we;
    mgm_pkg::key_idx_t             cfg_index;
    logic [mgm_pkg::KeyRegW-1:0]   cfg_data;

    mgm_stream_if #(.payload_t(mgm_pkg::req_t)) cipher_req_if ();
    mgm_stream_if #(.payload_t(mgm_pkg::rsp_t)) cipher_rsp_if ();

    // Key as the block should hold it, and the blocks still in flight.
    logic [63:0]  key_words [4];
    cipher_job_t  expected_blocks [$];

    bit           gaps_on;
    bit           stalls_on;
    int unsigned  error_count;
    int unsigned  blocks_sent;
    int unsigned  encrypt_count;
    int unsigned  key_loads;

    magma_block_cipher i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cipher_req (cipher_req_if),
        .cipher_rsp (cipher_rsp_if),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Round function: add the round key, substitute nibbles, rotate left by 11.
    function automatic logic [31:0] round_mix(input logic [31:0] x, input logic [31:0] k);
        logic [31:0] t;
        logic [31:0] s;
        int          i;
        t = x + k;
        s = '0;
        for (i = 0; i < 8; i++)
        begin
            s[4*i +: 4] = SUBST[i][t[4*i +: 4]];
        end
        return {s[20:0], s[31:21]};
    endfunction

    // Full 32-round Feistel transform under the current key.
    function automatic logic [63:0] magma_crypt(input logic dec, input logic [63:0] blk);
        logic [31:0] lh;
        logic [31:0] rh;
        logic [31:0] f;
        logic [31:0] rk;
        logic [63:0] part;
        logic [2:0]  kn;
        int          rnd;
        lh = blk[63:32];
        rh = blk[31:0];
        for (rnd = 0; rnd < 32; rnd++)
        begin
            if (dec)
                kn = (rnd < 8) ? 3'(rnd) : 3'(7 - (rnd % 8));
            else
                kn = (rnd < 24) ? 3'(rnd % 8) : 3'(7 - (rnd % 8));
            part = key_words[2'(3 - kn[2:1])];
            rk = kn[0] ? part[31:0] : part[63:32];
            f = round_mix(rh, rk) ^ lh;
            if (rnd < 31)
            begin
                lh = rh;
                rh = f;
            end
            else
            begin
                lh = f;
            end
        end
        return {lh, rh};
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Blocks biased toward the edges of the range now and then.
    function automatic logic [63:0] pick_block();
        int unsigned sel;
        sel = $urandom_range(0, 11);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        if (sel == 2)
            return {32'h0, 32'($urandom)};
        if (sel == 3)
            return {32'($urandom), 32'h0};
        if (sel == 4)
            return 64'h1 << $urandom_range(0, 63);
        return {32'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [63:0] pick_key_word();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return {32'($urandom), 32'($urandom)};
    endfunction

    task automatic report_mismatch(input string detail);
        if (error_count < MAX_PRINTED)
            $display("ERROR at %0t ns: %s", $time, detail);
        error_count++;
    endtask

    // Send one request, wait for it to be accepted, and record the expected block.
    task automatic send_block(input logic cmd, input logic [63:0] blk);
        int unsigned gap;
        cipher_job_t job;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            cipher_req_if.valid <= 1'b0;
            cipher_req_if.payload <= {1'($urandom), 32'($urandom), 32'($urandom)};
            repeat (gap) @(posedge clk);
        end
        cipher_req_if.valid <= 1'b1;
        cipher_req_if.payload.cmd <= cmd;
        cipher_req_if.payload.block_in <= blk;
        do
            @(posedge clk);
        while (cipher_req_if.ready !== 1'b1);
        job.cmd = cmd;
        job.block_in = blk;
        job.block_out = magma_crypt(cmd == mgm_pkg::CMD_DECRYPT, blk);
        expected_blocks.push_back(job);
        blocks_sent++;
        if (cmd == mgm_pkg::CMD_ENCRYPT)
            encrypt_count++;
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic drain_pipeline();
        cipher_req_if.valid <= 1'b0;
        while (expected_blocks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the key registers selected by the mask; the block must be idle.
    task automatic load_key(input logic [3:0] mask, input logic [3:0][63:0] key_set);
        int i;
        for (i = 0; i < 4; i++)
        begin
            if (mask[i])
            begin
                cfg_we <= 1'b1;
                cfg_index <= mgm_pkg::key_idx_t'(i);
                cfg_data <= key_set[i];
                @(posedge clk);
                key_words[i] = key_set[i];
            end
        end
        cfg_we <= 1'b0;
        key_loads++;
    endtask

    // Blocks at the field extremes under the reset key, before any write.
    task automatic test_zero_key_blocks();
        send_block(mgm_pkg::CMD_ENCRYPT, 64'h0);
        send_block(mgm_pkg::CMD_DECRYPT, 64'h0);
        send_block(mgm_pkg::CMD_ENCRYPT, 64'hffff_ffff_ffff_ffff);
        send_block(mgm_pkg::CMD_DECRYPT, 64'hffff_ffff_ffff_ffff);
        send_block(mgm_pkg::CMD_ENCRYPT, 64'h0000_0000_ffff_ffff);
        send_block(mgm_pkg::CMD_DECRYPT, 64'hffff_ffff_0000_0000);
        send_block(mgm_pkg::CMD_ENCRYPT, 64'h8000_0000_0000_0001);
        send_block(mgm_pkg::CMD_DECRYPT, 64'h5555_5555_aaaa_aaaa);
        drain_pipeline();
    endtask

    // The published example key and block, forward and back.
    task automatic test_standard_vector();
        load_key(4'hf, {64'hffee_ddcc_bbaa_9988, 64'h7766_5544_3322_1100,
                        64'hf0f1_f2f3_f4f5_f6f7, 64'hf8f9_fafb_fcfd_feff});
        send_block(mgm_pkg::CMD_ENCRYPT, 64'hfedc_ba98_7654_3210);
        send_block(mgm_pkg::CMD_DECRYPT, 64'h4ee9_01e5_c2d8_ca3d);
        send_block(mgm_pkg::CMD_ENCRYPT, 64'h0);
        send_block(mgm_pkg::CMD_DECRYPT, 64'hffff_ffff_ffff_ffff);
        send_block(mgm_pkg::CMD_ENCRYPT, 64'haaaa_aaaa_5555_5555);
        drain_pipeline();
    endtask

    // All-ones key, then a single key word changed on its own.
    task automatic test_extreme_keys();
        load_key(4'hf, {4{64'hffff_ffff_ffff_ffff}});
        send_block(mgm_pkg::CMD_ENCRYPT, 64'h0);
        send_block(mgm_pkg::CMD_DECRYPT, 64'h0);
        send_block(mgm_pkg::CMD_ENCRYPT, 64'hffff_ffff_ffff_ffff);
        send_block(mgm_pkg::CMD_DECRYPT, 64'hffff_ffff_ffff_ffff);
        drain_pipeline();
        load_key(4'b0010, {4{64'h0123_4567_89ab_cdef}});
        send_block(mgm_pkg::CMD_ENCRYPT, 64'h0123_4567_89ab_cdef);
        send_block(mgm_pkg::CMD_DECRYPT, 64'h0123_4567_89ab_cdef);
        send_block(mgm_pkg::CMD_ENCRYPT, 64'hffff_ffff_ffff_ffff);
        drain_pipeline();
    endtask

    // Random phases, each after a key load and with a chosen mix of idle gaps and stalls.
    task automatic test_random_traffic(input int unsigned phases, input int unsigned per_phase);
        int unsigned       phase;
        int unsigned       n;
        logic [3:0][63:0]  key_set;
        logic [3:0]        mask;
        logic              cmd;
        logic              last_cmd;
        logic [63:0]       blk;
        logic [63:0]       last_out;
        int                i;
        for (phase = 0; phase < phases; phase++)
        begin
            for (i = 0; i < 4; i++)
                key_set[i] = pick_key_word();
            if (phase == 0)
                key_set = '0;
            if (phase == 4)
                key_set = '1;
            mask = (phase == 6) ? 4'($urandom_range(1, 14)) : 4'hf;
            load_key(mask, key_set);
            gaps_on = (phase % 4 != 0) && (phase % 4 != 1);
            stalls_on = (phase % 4 != 0) && (phase % 4 != 2);
            if (phase >= 4)
            begin
                gaps_on = (phase != 4);
                stalls_on = 1'b1;
            end
            last_cmd = mgm_pkg::CMD_ENCRYPT;
            last_out = '0;
            for (n = 0; n < per_phase; n++)
            begin
                // Some requests undo the previous one to exercise the round trip.
                if (n > 0 && $urandom_range(0, 4) == 0)
                begin
                    cmd = ~last_cmd;
                    blk = last_out;
                end
                else
                begin
                    cmd = 1'($urandom);
                    blk = pick_block();
                end
                send_block(cmd, blk);
                last_cmd = cmd;
                last_out = magma_crypt(cmd == mgm_pkg::CMD_DECRYPT, blk);
            end
            drain_pipeline();
        end
    endtask

    // Result side: ready is held at a random level for random stretches, or high when stalls are off.
    initial
    begin : drive_result_ready
        int unsigned hold_cycles;
        int unsigned r;
        hold_cycles = 0;
        cipher_rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
            end
            else if (!stalls_on)
            begin
                cipher_rsp_if.ready <= 1'b1;
            end
            else
            begin
                cipher_rsp_if.ready <= ($urandom_range(0, 2) != 0);
                r = $urandom_range(0, 99);
                hold_cycles = (r < 90) ? $urandom_range(0, 3) : $urandom_range(10, 40);
            end
        end
    end

    // Compare each accepted result with the oldest outstanding request.
    always @(posedge clk)
    begin : check_results
        cipher_job_t job;
        if (rst_n === 1'b1 && cipher_rsp_if.valid === 1'b1 && cipher_rsp_if.ready === 1'b1)
        begin
            if (expected_blocks.size() == 0)
            begin
                report_mismatch($sformatf("result %h with no request outstanding",
                                          cipher_rsp_if.payload.block_out));
            end
            else
            begin
                job = expected_blocks.pop_front();
                if (cipher_rsp_if.payload.block_out !== job.block_out)
                    report_mismatch($sformatf("cmd %0d block_in %h: block_out %h, expected %h",
                                              job.cmd, job.block_in,
                                              cipher_rsp_if.payload.block_out, job.block_out));
            end
        end
    end

    initial
    begin : run_limit
        #10_000_000;
        $display("Timeout with %0d results outstanding", expected_blocks.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        cipher_req_if.valid <= 1'b0;
        cipher_req_if.payload <= '0;
        for (int i = 0; i < 4; i++)
            key_words[i] = '0;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        error_count = 0;
        blocks_sent = 0;
        encrypt_count = 0;
        key_loads = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_key_blocks();
        test_standard_vector();
        test_extreme_keys();
        test_random_traffic(8, 178);

        drain_pipeline();
        $display("Sent %0d blocks (%0d encrypt, %0d decrypt) under %0d key loads.",
                 blocks_sent, encrypt_count, blocks_sent - encrypt_count, key_loads);
        $display("Covered zero, all-ones, example and random keys with idle and stall mixes.");
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
src/mgm_pkg.sv
src/mgm_stream_if.sv
src/mgm_keys.sv
src/mgm_round.sv
src/magma_block_cipher.sv
test/magma_block_cipher_test.sv
